FILE: sv/ppd_pkg.sv
// ============================================================================
// ppd_pkg: shared constants, types and functions of the point pair distance core
// Holds fixed-point constants, the arctangent table and the pipeline latencies.
// ============================================================================
package ppd_pkg;

	localparam int FRAC_BITS = 20;

	localparam logic [63:0] HALF_DEG_K = ((64'd1 << (64 - FRAC_BITS)) + 64'd360) / 64'd720;
	localparam logic [63:0] FULL_DEG_K = ((64'd1 << (64 - FRAC_BITS)) + 64'd180) / 64'd360;
	localparam logic [32:0] TURN_KM_Q16 = 33'd5252919298;
	localparam logic [34:0] DIST_MAX = '1;

	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

	localparam int CORDIC_PER_STAGE = 3;
	localparam int CORDIC_STAGES = 10;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;

	localparam int SQRT_PER_STAGE = 3;
	localparam int SQRT_STAGES = 11;
	localparam int SQRT_LAT = SQRT_STAGES + 1;

	localparam int PIPE_LAT = 3 + CORDIC_LAT + 3 + SQRT_LAT + CORDIC_LAT + 2;
	localparam int EU_DLY = PIPE_LAT - 3 - SQRT_LAT - 1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_state_t;

	typedef struct packed {
		logic [65:0] rad;
		logic [36:0] rem;
		logic [33:0] res;
	} sqrt_state_t;

	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'd536870912;
			1: v = 32'd316933405;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Q30 product, rounded half up.
	function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b + (68'sd1 <<< 29);
		p = p >>> 30;
		return p[CW-1:0];
	endfunction

endpackage

FILE: sv/point_pair_distance_core.sv
// ============================================================================
// point_pair_distance_core: Euclidean or great-circle distance of a point pair
// Pipelined haversine and Euclidean distance, one point pair per cycle while the output is not stalled.
// ============================================================================
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_ready    first_x, first_y, second_x, second_y
//  out      out_valid / out_ready  distance
//  cfg      cfg_valid / cfg_ready  geographic_mode
//
// One word enters every cycle unless the pipeline holds for a waiting output word.
// The latency is set by two 30-step CORDIC pipelines and a 33-digit root.
// The whole pipeline holds while the output word waits and out_ready is low.
// Reset clears the valid bits and selects Euclidean mode.
//
module point_pair_distance_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [34:0]        distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               geographic_mode
);

	localparam int CW = ppd_pkg::CW;
	localparam int FB = ppd_pkg::FRAC_BITS;

	logic en;
	logic mode_q;
	logic [ppd_pkg::PIPE_LAT-1:0] vld_q;

	assign en = !vld_q[ppd_pkg::PIPE_LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[ppd_pkg::PIPE_LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ppd_pkg::PIPE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= geographic_mode;
		end
	end

	// Angles: half latitude difference, half longitude difference, both latitudes.
	logic signed [32:0] ang_s1 [4];
	logic signed [32:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= 33'(second_y) - 33'(first_y);
			ang_s1[1] <= 33'(second_x) - 33'(first_x);
			ang_s1[2] <= 33'(first_y);
			ang_s1[3] <= 33'(second_y);
			dx_s1 <= 33'(first_x) - 33'(second_x);
			dy_s1 <= 33'(first_y) - 33'(second_y);
		end
	end

	logic [63:0] lo_c [4];
	logic [31:0] hi_c [4];
	logic [31:0] ax_c, ay_c;

	always_comb begin
		logic [63:0] kk;
		logic signed [64:0] plo;
		logic signed [64:0] phi;
		for (int i = 0; i < 4; i++) begin
			kk = (i < 2) ? ppd_pkg::HALF_DEG_K : ppd_pkg::FULL_DEG_K;
			plo = ang_s1[i] * $signed({1'b0, kk[31:0]});
			phi = ang_s1[i] * $signed({1'b0, kk[63:32]});
			lo_c[i] = plo[63:0];
			hi_c[i] = phi[31:0];
		end
		ax_c = dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		ay_c = dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
	end

	logic [63:0] lo_s2 [4];
	logic [31:0] hi_s2 [4];
	logic [63:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= lo_c;
			hi_s2 <= hi_c;
			sqx_s2 <= 64'(ax_c) * 64'(ax_c);
			sqy_s2 <= 64'(ay_c) * 64'(ay_c);
		end
	end

	logic [31:0] phase_s3 [4];
	logic [64:0] sum_s3;

	always_ff @(posedge clk) begin
		logic [63:0] p;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p = lo_s2[i] + {hi_s2[i], 32'd0} + 64'h0000_0000_8000_0000;
				phase_s3[i] <= p[63:32];
			end
			sum_s3 <= 65'(sqx_s2) + 65'(sqy_s2);
		end
	end

	logic signed [CW-1:0] sin_w [4];
	logic signed [CW-1:0] cos_w [4];

	for (genvar i = 0; i < 4; i++) begin : g_rot
		ppd_cordic u_rot (
			.clk       (clk),
			.en        (en),
			.vectoring (1'b0),
			.x_in      (ppd_pkg::CORDIC_GAIN_Q30),
			.y_in      ('0),
			.z_in      (34'($signed(phase_s3[i]))),
			.x_out     (cos_w[i]),
			.y_out     (sin_w[i]),
			.z_out     ()
		);
	end

	logic [33:0] eu_root;

	ppd_sqrt u_eu_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_in ({1'b0, sum_s3}),
		.root   (eu_root)
	);

	logic [33:0] eu_dly [ppd_pkg::EU_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			eu_dly[0] <= eu_root;
			for (int i = 1; i < ppd_pkg::EU_DLY; i++) begin
				eu_dly[i] <= eu_dly[i-1];
			end
		end
	end

	logic signed [CW-1:0] p1_s16, p2_s16, p3_s16;
	logic signed [CW-1:0] p1_s17, p4_s17;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s16 <= ppd_pkg::mul_q30(sin_w[0], sin_w[0]);
			p2_s16 <= ppd_pkg::mul_q30(cos_w[2], cos_w[3]);
			p3_s16 <= ppd_pkg::mul_q30(sin_w[1], sin_w[1]);
			p1_s17 <= p1_s16;
			p4_s17 <= ppd_pkg::mul_q30(p2_s16, p3_s16);
		end
	end

	logic signed [CW:0] hsum_c;
	logic [30:0] h_c;
	logic [30:0] h_s18, om_s18;

	always_comb begin
		hsum_c = 35'(p1_s17) + 35'(p4_s17);
		if (hsum_c < 0) begin
			h_c = '0;
		end else if (hsum_c > 35'(ppd_pkg::ONE_Q30)) begin
			h_c = 31'(ppd_pkg::ONE_Q30);
		end else begin
			h_c = hsum_c[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s18 <= h_c;
			om_s18 <= 31'(ppd_pkg::ONE_Q30) - h_c;
		end
	end

	logic [33:0] a_root, b_root;

	ppd_sqrt u_a_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_in ({5'd0, h_s18, 30'd0}),
		.root   (a_root)
	);

	ppd_sqrt u_b_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_in ({5'd0, om_s18, 30'd0}),
		.root   (b_root)
	);

	logic signed [CW-1:0] ang_z;

	ppd_cordic u_vec (
		.clk       (clk),
		.en        (en),
		.vectoring (1'b1),
		.x_in      ($signed(b_root)),
		.y_in      ($signed(a_root)),
		.z_in      ('0),
		.x_out     (),
		.y_out     (),
		.z_out     (ang_z)
	);

	logic [64:0] prod_s43;
	logic [31:0] zc_c;

	assign zc_c = ang_z[CW-1] ? 32'd0 : ang_z[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s43 <= 65'(zc_c) * 65'(ppd_pkg::TURN_KM_Q16);
		end
	end

	logic [64:0] geo_c;
	logic [34:0] geo_sat_c;
	logic [34:0] dist_s44;

	always_comb begin
		geo_c = (prod_s43 + (65'd1 << (47 - FB))) >> (48 - FB);
		geo_sat_c = (geo_c > 65'(ppd_pkg::DIST_MAX)) ? ppd_pkg::DIST_MAX : geo_c[34:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s44 <= mode_q ? geo_sat_c : {1'b0, eu_dly[ppd_pkg::EU_DLY-1]};
		end
	end

	assign distance = dist_s44;

endmodule

FILE: sv/ppd_cordic.sv
// ============================================================================
// ppd_cordic: pipelined CORDIC, rotation or vectoring
// Three iterations per stage, one word per cycle, advances while en is high.
// ============================================================================
module ppd_cordic (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           vectoring,
	input  logic signed [ppd_pkg::CW-1:0]  x_in,
	input  logic signed [ppd_pkg::CW-1:0]  y_in,
	input  logic signed [ppd_pkg::CW-1:0]  z_in,
	output logic signed [ppd_pkg::CW-1:0]  x_out,
	output logic signed [ppd_pkg::CW-1:0]  y_out,
	output logic signed [ppd_pkg::CW-1:0]  z_out
);

	function automatic ppd_pkg::cordic_state_t step(input ppd_pkg::cordic_state_t s,
			input int unsigned i, input logic vec);
		ppd_pkg::cordic_state_t r;
		logic dir;
		logic signed [ppd_pkg::CW-1:0] a;
		a = $signed({2'b00, ppd_pkg::atan_turn(i)});
		dir = vec ? (s.y <= 0) : (s.z >= 0);
		if (dir) begin
			r.x = s.x - (s.y >>> i);
			r.y = s.y + (s.x >>> i);
			r.z = s.z - a;
		end else begin
			r.x = s.x + (s.y >>> i);
			r.y = s.y - (s.x >>> i);
			r.z = s.z + a;
		end
		return r;
	endfunction

	ppd_pkg::cordic_state_t st_s [ppd_pkg::CORDIC_STAGES+1];
	logic neg_s [ppd_pkg::CORDIC_STAGES+1];
	logic fold;
	ppd_pkg::cordic_state_t prep;

	always_comb begin
		fold = !vectoring && (z_in > ppd_pkg::ONE_Q30 || z_in < -ppd_pkg::ONE_Q30);
		prep.x = x_in;
		prep.y = y_in;
		prep.z = fold ? $signed({{2{~z_in[31]}}, ~z_in[31], z_in[30:0]}) : z_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep;
			neg_s[0] <= fold;
		end
	end

	for (genvar k = 1; k <= ppd_pkg::CORDIC_STAGES; k++) begin : g_stage
		ppd_pkg::cordic_state_t nxt;
		always_comb begin
			nxt = st_s[k-1];
			for (int j = 0; j < ppd_pkg::CORDIC_PER_STAGE; j++) begin
				nxt = step(nxt, (k - 1) * ppd_pkg::CORDIC_PER_STAGE + j, vectoring);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= neg_s[ppd_pkg::CORDIC_STAGES] ? -st_s[ppd_pkg::CORDIC_STAGES].x
				: st_s[ppd_pkg::CORDIC_STAGES].x;
			y_out <= neg_s[ppd_pkg::CORDIC_STAGES] ? -st_s[ppd_pkg::CORDIC_STAGES].y
				: st_s[ppd_pkg::CORDIC_STAGES].y;
			z_out <= st_s[ppd_pkg::CORDIC_STAGES].z;
		end
	end

endmodule

FILE: sv/ppd_sqrt.sv
// ============================================================================
// ppd_sqrt: pipelined square root with round to nearest
// Digit-by-digit root of a 66-bit radicand, three digits per stage.
// ============================================================================
module ppd_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [65:0] rad_in,
	output logic [33:0] root
);

	function automatic ppd_pkg::sqrt_state_t iter(input ppd_pkg::sqrt_state_t s);
		ppd_pkg::sqrt_state_t r;
		logic [36:0] rem2;
		logic [36:0] trial;
		rem2 = {s.rem[34:0], s.rad[65:64]};
		trial = {1'b0, s.res, 2'b01};
		r.rad = {s.rad[63:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem = rem2 - trial;
			r.res = {s.res[32:0], 1'b1};
		end else begin
			r.rem = rem2;
			r.res = {s.res[32:0], 1'b0};
		end
		return r;
	endfunction

	ppd_pkg::sqrt_state_t st_s [ppd_pkg::SQRT_STAGES];

	for (genvar k = 0; k < ppd_pkg::SQRT_STAGES; k++) begin : g_stage
		ppd_pkg::sqrt_state_t nxt;
		if (k == 0) begin : g_first
			always_comb begin
				nxt.rad = rad_in;
				nxt.rem = '0;
				nxt.res = '0;
				for (int j = 0; j < ppd_pkg::SQRT_PER_STAGE; j++) begin
					nxt = iter(nxt);
				end
			end
		end else begin : g_next
			always_comb begin
				nxt = st_s[k-1];
				for (int j = 0; j < ppd_pkg::SQRT_PER_STAGE; j++) begin
					nxt = iter(nxt);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root <= st_s[ppd_pkg::SQRT_STAGES-1].res
				+ 34'(st_s[ppd_pkg::SQRT_STAGES-1].rem > {3'b000, st_s[ppd_pkg::SQRT_STAGES-1].res});
		end
	end

endmodule

FILE: sv/ppd_checker.sv
// ============================================================================
// ppd_checker: port-level checks of the point pair distance core
// Watches handshakes and backpressure on the top-level ports.
// ============================================================================
module ppd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [34:0] distance,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A stalled output word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance))
		else $error("output word changed while stalled");

	// A stalled output stops the pipeline from taking input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// With no word waiting at the output the pipeline always moves.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready && cfg_ready)
		else $error("pipeline stalled without a waiting word");

	// A configuration write is always taken in the cycle it is offered.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind point_pair_distance_core ppd_checker u_ppd_checker (.*);
